>>> rtl/core/necd_pkg.sv
package necd_pkg;

   localparam int TIME_W = 16;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [5:0] FRAME_PULSES = 6'd34;
   localparam logic [5:0] REPEAT_PULSES = 6'd2;
   localparam logic [5:0] PULSE_LIMIT = 6'd35;
   localparam logic [5:0] FIRST_BIT_PULSE = 6'd2;

   typedef enum logic [0:0] {
      REQ_PULSE = 1'b0,
      REQ_TICK  = 1'b1
   } necd_item_kind_type;

   typedef enum logic [1:0] {
      KIND_REJECT      = 2'd0,
      KIND_DATA        = 2'd1,
      KIND_REPEAT_LIVE = 2'd2,
      KIND_REPEAT_DEAD = 2'd3
   } necd_kind_type;

   typedef enum logic [2:0] {
      REG_AGC_MARK      = 3'd0,
      REG_LONG_SPACE    = 3'd1,
      REG_SHORT_SPACE   = 3'd2,
      REG_BIT_MARK      = 3'd3,
      REG_ONE_SPACE     = 3'd4,
      REG_ZERO_SPACE    = 3'd5,
      REG_IDLE_TICKS    = 3'd6,
      REG_REPEAT_WINDOW = 3'd7
   } necd_reg_type;

   typedef struct packed {
      logic              req_type;
      logic [TIME_W-1:0] mark_start;
      logic [TIME_W-1:0] mark_end;
   } necd_req_type;

   typedef struct packed {
      logic [1:0] frame_kind;
      logic [7:0] address;
      logic [7:0] address_inverse;
      logic [7:0] command;
      logic [7:0] command_inverse;
   } necd_rsp_type;

   typedef struct packed {
      logic [TIME_W-1:0] agc_mark;
      logic [TIME_W-1:0] long_space;
      logic [TIME_W-1:0] short_space;
      logic [TIME_W-1:0] bit_mark;
      logic [TIME_W-1:0] one_space;
      logic [TIME_W-1:0] zero_space;
      logic [7:0]        idle_ticks;
      logic [15:0]       repeat_window;
   } necd_cfg_type;

endpackage

>>> rtl/core/nec_ir_pulse_decoder_top.sv
// Channel   Direction  Handshake             Beat
// req       in         req_valid/req_stall   pulse timestamps or one timer tick
// rsp       out        rsp_valid/rsp_stall   frame kind and four frame bytes
// csr       in         psel/penable/pready   one 32-bit register write or read
//
// An accepted beat is held in an input register and is decoded once the result register is free,
// when the frame state and the result register update together.
// A new beat is accepted every cycle that the input does not stall, so the decoder then takes one item per cycle.
// A result is built when its closing tick is decoded and waits in the result register.
// The input stalls only while the input register holds a beat and a stalled result is waiting.
// Reset is synchronous and restores the register defaults and an empty frame.
module nec_ir_pulse_decoder_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  necd_pkg::necd_req_type           req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output necd_pkg::necd_rsp_type           rsp_data,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [necd_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [necd_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [necd_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);
   import necd_pkg::*;

   function automatic logic near_fn(input logic [TIME_W-1:0] d, input logic [TIME_W-1:0] t);
      logic [TIME_W+2:0] d5;
      logic [TIME_W+2:0] t4;
      logic [TIME_W+2:0] t6;
      d5 = {3'b000, d} + {1'b0, d, 2'b00};
      t4 = {1'b0, t, 2'b00};
      t6 = {1'b0, t, 2'b00} + {2'b00, t, 1'b0};
      return (t4 < d5) && (d5 < t6);
   endfunction

   necd_cfg_type      cfg;
   necd_req_type      item_ff;
   logic              item_valid_ff;
   necd_rsp_type      rsp_ff;
   necd_rsp_type      rsp_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;

   logic [TIME_W-1:0] prev_end_ff;
   logic [TIME_W-1:0] prev_end_in;
   logic [5:0]        pulse_count_ff;
   logic [5:0]        pulse_count_in;
   logic              data_ok_ff;
   logic              data_ok_in;
   logic              repeat_ok_ff;
   logic              repeat_ok_in;
   logic [31:0]       bit_shift_ff;
   logic [31:0]       bit_shift_in;
   logic [7:0]        idle_age_ff;
   logic [7:0]        idle_age_in;
   logic [15:0]       repeat_age_ff;
   logic [15:0]       repeat_age_in;
   logic              key_live_ff;
   logic              key_live_in;
   logic [31:0]       last_frame_ff;
   logic [31:0]       last_frame_in;

   logic              out_free;
   logic              advance;
   logic              close_frame;
   logic              fresh;
   logic [TIME_W-1:0] mark_w;
   logic [TIME_W-1:0] space_w;
   logic [5:0]        pc_minus2;
   logic [4:0]        bit_idx;
   logic              mark_is_bit;

   necd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = item_valid_ff && out_free;
   assign req_stall = item_valid_ff && !out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign mark_w      = item_ff.mark_end - item_ff.mark_start;
   assign space_w     = item_ff.mark_start - prev_end_ff;
   assign pc_minus2   = pulse_count_ff - FIRST_BIT_PULSE;
   assign bit_idx     = pc_minus2[4:0];
   assign mark_is_bit = near_fn(mark_w, cfg.bit_mark);

   always_comb begin
      prev_end_in    = prev_end_ff;
      pulse_count_in = pulse_count_ff;
      data_ok_in     = data_ok_ff;
      repeat_ok_in   = repeat_ok_ff;
      bit_shift_in   = bit_shift_ff;
      idle_age_in    = idle_age_ff;
      repeat_age_in  = repeat_age_ff;
      key_live_in    = key_live_ff;
      last_frame_in  = last_frame_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      close_frame    = 1'b0;
      fresh          = 1'b0;
      if (advance) begin
         if (item_ff.req_type == REQ_PULSE) begin
            if (pulse_count_ff == '0) begin
               if (!near_fn(mark_w, cfg.agc_mark)) begin
                  data_ok_in   = 1'b0;
                  repeat_ok_in = 1'b0;
               end
            end else if (pulse_count_ff == 6'd1) begin
               if (!near_fn(space_w, cfg.long_space) || !mark_is_bit) begin
                  data_ok_in = 1'b0;
               end
               if (!near_fn(space_w, cfg.short_space) || !mark_is_bit) begin
                  repeat_ok_in = 1'b0;
               end
            end else if (pulse_count_ff < FRAME_PULSES) begin
               if (near_fn(space_w, cfg.one_space)) begin
                  bit_shift_in[bit_idx] = 1'b1;
               end else if (!near_fn(space_w, cfg.zero_space)) begin
                  data_ok_in = 1'b0;
               end
               if (!mark_is_bit) begin
                  data_ok_in = 1'b0;
               end
            end
            if (pulse_count_ff < PULSE_LIMIT) begin
               pulse_count_in = pulse_count_ff + 6'd1;
            end
            prev_end_in = item_ff.mark_end;
            idle_age_in = '0;
         end else begin
            if (pulse_count_ff != '0) begin
               if (idle_age_ff >= cfg.idle_ticks) begin
                  close_frame  = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
                  rsp_in.frame_kind = KIND_REJECT;
                  if (pulse_count_ff == FRAME_PULSES && data_ok_ff) begin
                     fresh         = 1'b1;
                     last_frame_in = bit_shift_ff;
                     key_live_in   = 1'b1;
                     repeat_age_in = '0;
                     rsp_in.frame_kind      = KIND_DATA;
                     rsp_in.address         = bit_shift_ff[7:0];
                     rsp_in.address_inverse = bit_shift_ff[15:8];
                     rsp_in.command         = bit_shift_ff[23:16];
                     rsp_in.command_inverse = bit_shift_ff[31:24];
                  end else if (pulse_count_ff == REPEAT_PULSES && repeat_ok_ff) begin
                     if (key_live_ff) begin
                        rsp_in.frame_kind      = KIND_REPEAT_LIVE;
                        rsp_in.address         = last_frame_ff[7:0];
                        rsp_in.address_inverse = last_frame_ff[15:8];
                        rsp_in.command         = last_frame_ff[23:16];
                        rsp_in.command_inverse = last_frame_ff[31:24];
                     end else begin
                        rsp_in.frame_kind = KIND_REPEAT_DEAD;
                     end
                  end
                  pulse_count_in = '0;
                  data_ok_in     = 1'b1;
                  repeat_ok_in   = 1'b1;
                  bit_shift_in   = '0;
                  idle_age_in    = '0;
               end else begin
                  idle_age_in = idle_age_ff + 8'd1;
               end
            end
            if (key_live_ff && !fresh) begin
               if (repeat_age_ff >= cfg.repeat_window) begin
                  key_live_in   = 1'b0;
                  repeat_age_in = '0;
               end else begin
                  repeat_age_in = repeat_age_ff + 16'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         item_ff <= req_data;
      end
      rsp_ff <= rsp_in;
      if (reset) begin
         item_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         prev_end_ff    <= '0;
         pulse_count_ff <= '0;
         data_ok_ff     <= 1'b1;
         repeat_ok_ff   <= 1'b1;
         bit_shift_ff   <= '0;
         idle_age_ff    <= '0;
         repeat_age_ff  <= '0;
         key_live_ff    <= 1'b0;
         last_frame_ff  <= '0;
      end else begin
         if (!req_stall) begin
            item_valid_ff <= req_valid;
         end
         rsp_valid_ff   <= rsp_valid_in;
         prev_end_ff    <= prev_end_in;
         pulse_count_ff <= pulse_count_in;
         data_ok_ff     <= data_ok_in;
         repeat_ok_ff   <= repeat_ok_in;
         bit_shift_ff   <= bit_shift_in;
         idle_age_ff    <= idle_age_in;
         repeat_age_ff  <= repeat_age_in;
         key_live_ff    <= key_live_in;
         last_frame_ff  <= last_frame_in;
      end
   end

   a_empty_bytes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.frame_kind == KIND_REJECT ||
                        rsp_ff.frame_kind == KIND_REPEAT_DEAD))
      |-> (rsp_ff.address == '0 && rsp_ff.address_inverse == '0 &&
           rsp_ff.command == '0 && rsp_ff.command_inverse == '0))
      else $error("Rejected or dead repeat result carries nonzero bytes.");

   a_close_opens: assert property (@(posedge clock) disable iff (reset)
      (advance && close_frame) |=> (pulse_count_ff == '0 && rsp_valid_ff))
      else $error("Closed frame did not reopen or lost its result.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      pulse_count_ff <= PULSE_LIMIT)
      else $error("Pulse count passed its saturation limit.");

   a_dead_key_age: assert property (@(posedge clock) disable iff (reset)
      !key_live_ff |-> (repeat_age_ff == '0))
      else $error("Key age is nonzero while no key is live.");

endmodule

>>> rtl/core/necd_csr.sv
module necd_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [necd_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [necd_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [necd_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready,
   output necd_pkg::necd_cfg_type           cfg
);
   import necd_pkg::*;

   necd_cfg_type cfg_ff;
   necd_cfg_type cfg_in;
   necd_reg_type reg_sel;
   logic         write_en;

   assign reg_sel  = necd_reg_type'(paddr[CSR_ADDR_W-1:2]);
   assign write_en = psel && penable && pwrite;
   assign pready   = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_sel)
            REG_AGC_MARK:      cfg_in.agc_mark      = pwdata[TIME_W-1:0];
            REG_LONG_SPACE:    cfg_in.long_space    = pwdata[TIME_W-1:0];
            REG_SHORT_SPACE:   cfg_in.short_space   = pwdata[TIME_W-1:0];
            REG_BIT_MARK:      cfg_in.bit_mark      = pwdata[TIME_W-1:0];
            REG_ONE_SPACE:     cfg_in.one_space     = pwdata[TIME_W-1:0];
            REG_ZERO_SPACE:    cfg_in.zero_space    = pwdata[TIME_W-1:0];
            REG_IDLE_TICKS:    cfg_in.idle_ticks    = pwdata[7:0];
            REG_REPEAT_WINDOW: cfg_in.repeat_window = pwdata[15:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      case (reg_sel)
         REG_AGC_MARK:      prdata = CSR_DATA_W'(cfg_ff.agc_mark);
         REG_LONG_SPACE:    prdata = CSR_DATA_W'(cfg_ff.long_space);
         REG_SHORT_SPACE:   prdata = CSR_DATA_W'(cfg_ff.short_space);
         REG_BIT_MARK:      prdata = CSR_DATA_W'(cfg_ff.bit_mark);
         REG_ONE_SPACE:     prdata = CSR_DATA_W'(cfg_ff.one_space);
         REG_ZERO_SPACE:    prdata = CSR_DATA_W'(cfg_ff.zero_space);
         REG_IDLE_TICKS:    prdata = CSR_DATA_W'(cfg_ff.idle_ticks);
         REG_REPEAT_WINDOW: prdata = CSR_DATA_W'(cfg_ff.repeat_window);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.agc_mark      <= 16'd9000;
         cfg_ff.long_space    <= 16'd4500;
         cfg_ff.short_space   <= 16'd2250;
         cfg_ff.bit_mark      <= 16'd560;
         cfg_ff.one_space     <= 16'd1680;
         cfg_ff.zero_space    <= 16'd560;
         cfg_ff.idle_ticks    <= 8'd15;
         cfg_ff.repeat_window <= 16'd440;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
